/* sv/pmgv_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the galactic
// velocity unit. Depends on nothing; all files but pmgv_in_if and pmgv_mulq import it.
package pmgv_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int ATAN_LEN          = 30;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 25;
  localparam int VEL_W             = 48;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_EPOCH = 3'd0,
    CFG_SUN_U       = 3'd1,
    CFG_SUN_V       = 3'd2,
    CFG_SUN_W       = 3'd3,
    CFG_DISK_ROT    = 3'd4
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic signed [23:0] SUN_U_RST = -24'sd589824;
  localparam logic signed [23:0] SUN_V_RST = 24'sd786432;
  localparam logic signed [23:0] SUN_W_RST = 24'sd458752;
  localparam logic [24:0]        DISK_RST  = 25'd14417920;

  // Folded angle in 2^-24 degree plus a flag to negate the rotated vector
  typedef struct packed {
    logic signed [32:0] z;
    logic               neg;
  } ang_t;

  typedef logic [31:0] q30_t;
  typedef q30_t [8:0] mat_t;   // row-major, entry 3*row+col

  typedef struct packed {
    longint c;
    longint s;
  } sc_t;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
  localparam logic [22:0]        KTAN_Q20 = 23'd4970848;

  // Arctangent of 2^-i in 2^-24 degree
  localparam logic signed [31:0] ATAN_LUT [ATAN_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115,
    32'sd57,        32'sd29,        32'sd14,        32'sd7,
    32'sd4,         32'sd2
  };

  // Smallest q such that k * 2^q reaches bound
  function automatic int qbits(longint bound, longint k);
    int q;
    q = 0;
    for (int i = 0; i < 40; i++) begin
      if ((k <<< q) < bound) q = q + 1;
    end
    return q;
  endfunction

  function automatic longint clamp_c(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint mq_c(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Bit-exact CORDIC sine and cosine, evaluated at elaboration
  function automatic sc_t sincos_c(longint z_in, int stages);
    longint full;
    longint half;
    longint quart;
    longint x;
    longint y;
    longint t;
    longint z;
    bit     neg;
    sc_t    r;
    full  = 64'sd360 <<< 24;
    half  = 64'sd180 <<< 24;
    quart = 64'sd90 <<< 24;
    x     = 64'sd652032874;
    y     = 0;
    neg   = 1'b0;
    z     = z_in;
    // Bring the pole angle into one turn
    for (int k = 0; k < 4; k++) begin
      if (z >= full) z = z - full;
      if (z < 0) z = z + full;
    end
    if (z >= half) z = z - full;
    if (z > quart) begin
      z   = z - half;
      neg = 1'b1;
    end else if (z < -quart) begin
      z   = z + half;
      neg = 1'b1;
    end
    for (int i = 0; i < ATAN_LEN; i++) begin
      if (i < stages) begin
        t = x;
        if (z >= 0) begin
          x = x - (y >>> i);
          y = y + (t >>> i);
          z = z - longint'(ATAN_LUT[i]);
        end else begin
          x = x + (y >>> i);
          y = y - (t >>> i);
          z = z + longint'(ATAN_LUT[i]);
        end
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    r.c = clamp_c(x);
    r.s = clamp_c(y);
    return r;
  endfunction

  // Equatorial-to-galactic rotation for one pole, 0 J2000 and 1 B1950
  function automatic mat_t pole_matrix(bit ep, int stages);
    sc_t    pa;
    sc_t    pd;
    sc_t    pt;
    longint ca;
    longint sa;
    longint cd;
    longint sd;
    longint ct;
    longint st;
    mat_t   m;
    if (ep) begin
      pa = sincos_c(64'sd3225419776, stages);
      pd = sincos_c(64'sd459695718, stages);
      pt = sincos_c(64'sd2063597568, stages);
    end else begin
      pa = sincos_c(64'sd3235645174, stages);
      pd = sincos_c(64'sd455136530, stages);
      pt = sincos_c(64'sd2062455352, stages);
    end
    ca = pa.c;
    sa = pa.s;
    cd = pd.c;
    sd = pd.s;
    ct = pt.c;
    st = pt.s;
    m[0] = 32'(clamp_c(-mq_c(mq_c(ca, ct), sd) - mq_c(sa, st)));
    m[1] = 32'(clamp_c(-mq_c(mq_c(ct, sa), sd) + mq_c(ca, st)));
    m[2] = 32'(clamp_c(mq_c(cd, ct)));
    m[3] = 32'(clamp_c(mq_c(ct, sa) - mq_c(mq_c(ca, sd), st)));
    m[4] = 32'(clamp_c(-mq_c(mq_c(sa, sd), st) - mq_c(ca, ct)));
    m[5] = 32'(clamp_c(mq_c(cd, st)));
    m[6] = 32'(clamp_c(mq_c(cd, ca)));
    m[7] = 32'(clamp_c(mq_c(cd, sa)));
    m[8] = 32'(sd);
    return m;
  endfunction

endpackage

/* sv/pmgv_in_if.sv */
`timescale 1ns / 1ps
// Star input channel: valid/ready handshake with the star's fields.
// Depends on nothing.
interface pmgv_in_if;
  logic                valid;
  logic                ready;
  logic        [24:0]  ra_angle;
  logic signed [23:0]  dec_angle;
  logic        [22:0]  distance;
  logic signed [31:0]  pm_ra;
  logic signed [31:0]  pm_dec;
  logic signed [28:0]  radial_speed;

  modport source (output valid, ra_angle, dec_angle, distance, pm_ra, pm_dec,
                  radial_speed, input ready);
  modport sink   (input valid, ra_angle, dec_angle, distance, pm_ra, pm_dec,
                  radial_speed, output ready);
endinterface

/* sv/pmgv_out_if.sv */
`timescale 1ns / 1ps
// Velocity result channel: valid/ready handshake with U/V/W and clip flag.
// Depends on pmgv_pkg.
interface pmgv_out_if import pmgv_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  logic                    saturated;

  modport source (output valid, vel_x, vel_y, vel_z, saturated, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, saturated, output ready);
endinterface

/* sv/pmgv_mulq.sv */
`timescale 1ns / 1ps
// Two-stage Q30 multiplier: round(a * b / 2^30), half up.
// Depends on nothing; a is split in two partial products.
module pmgv_mulq #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW:0]   p_o
);
  localparam int LOW = 20;
  localparam int SW  = AW + BW + 1;
  localparam logic signed [SW-1:0] Half = {{(SW-30){1'b0}}, 1'b1, 29'd0};

  logic signed [AW-LOW-1:0]   hi;
  logic signed [LOW:0]        lo;
  logic signed [AW-LOW+BW-1:0] pph_q;
  logic signed [LOW+BW:0]     ppl_q;
  logic signed [SW-1:0]       sum;
  logic signed [AW:0]         p_q;

  assign hi = a_i[AW-1:LOW];
  assign lo = signed'({1'b0, a_i[LOW-1:0]});

  // Form partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pph_q <= hi * b_i;
      ppl_q <= lo * b_i;
    end
  end

  // Combine, round and scale
  assign sum = (SW'(pph_q) <<< LOW) + SW'(ppl_q) + Half;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum[AW+30:30];
    end
  end

  assign p_o = p_q;
endmodule

/* sv/pmgv_cordic.sv */
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC, one iteration per stage, then sign fix
// and clamp. Depends on pmgv_pkg for the gain and arctangent table.
module pmgv_cordic import pmgv_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  ang_t               ang_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  logic signed [33:0] x_in [STAGES];
  logic signed [33:0] y_in [STAGES];
  logic signed [32:0] z_in [STAGES];
  logic               n_in [STAGES];
  logic signed [33:0] x_q  [STAGES];
  logic signed [33:0] y_q  [STAGES];
  logic signed [32:0] z_q  [STAGES];
  logic               n_q  [STAGES];
  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [31:0] c_q;
  logic signed [31:0] s_q;

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    if (i == 0) begin : g_first
      assign x_in[i] = GAIN_Q30;
      assign y_in[i] = '0;
      assign z_in[i] = ang_i.z;
      assign n_in[i] = ang_i.neg;
    end else begin : g_next
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign z_in[i] = z_q[i-1];
      assign n_in[i] = n_q[i-1];
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i] <= n_in[i];
        if (z_in[i] >= 0) begin
          x_q[i] <= x_in[i] - (y_in[i] >>> i);
          y_q[i] <= y_in[i] + (x_in[i] >>> i);
          z_q[i] <= z_in[i] - 33'(ATAN_LUT[i]);
        end else begin
          x_q[i] <= x_in[i] + (y_in[i] >>> i);
          y_q[i] <= y_in[i] - (x_in[i] >>> i);
          z_q[i] <= z_in[i] + 33'(ATAN_LUT[i]);
        end
      end
    end
  end

  // Undo the half-turn fold
  assign xf = n_q[STAGES-1] ? -x_q[STAGES-1] : x_q[STAGES-1];
  assign yf = n_q[STAGES-1] ? -y_q[STAGES-1] : y_q[STAGES-1];

  // Clamp to the Q30 unit range
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (xf > 34'(ONE_Q30))       c_q <= ONE_Q30;
      else if (xf < -34'(ONE_Q30)) c_q <= -ONE_Q30;
      else                         c_q <= xf[31:0];
      if (yf > 34'(ONE_Q30))       s_q <= ONE_Q30;
      else if (yf < -34'(ONE_Q30)) s_q <= -ONE_Q30;
      else                         s_q <= yf[31:0];
    end
  end

  assign cos_o = c_q;
  assign sin_o = s_q;
endmodule

/* sv/proper_motion_to_galactic_velocity_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// star_i    in   valid/ready   ra_angle, dec_angle, distance, pm_ra, pm_dec, radial_speed
// vel_o     out  valid/ready   vel_x, vel_y, vel_z, saturated
// cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// One star enters per cycle while vel_o is not stalled; the path runs through the
// input register, the CORDIC iteration stages and three two-stage multiply layers.
// Reset clears valid bits and loads the configuration reset values only.
// A stalled result freezes the whole pipeline; star_i.ready drops in the
// same cycle, so no beat is lost or repeated.
// Depends on pmgv_pkg, pmgv_in_if, pmgv_out_if, pmgv_mulq, pmgv_cordic.
module proper_motion_to_galactic_velocity_unit import pmgv_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pmgv_in_if.sink               star_i,
  pmgv_out_if.source            vel_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int NS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int LAT = NS + 11;
  localparam int TW  = 60 - FRAC_BITS;
  localparam int EW  = TW + 3;
  localparam int UW  = EW + 3;
  localparam int FW  = (UW + 2 > VEL_W + 1) ? UW + 2 : VEL_W + 1;

  localparam longint KF   = 64'sd360 <<< FRAC_BITS;
  localparam longint HF   = 64'sd180 <<< FRAC_BITS;
  localparam longint QF   = 64'sd90 <<< FRAC_BITS;
  localparam int     RQB  = qbits(64'sd1 <<< 25, KF);
  localparam longint DOFF = (((64'sd1 <<< 23) + KF - 1) / KF) * KF;
  localparam int     DQB  = qbits((64'sd1 <<< 23) + DOFF, KF);

  localparam mat_t MAT_J = pole_matrix(1'b0, NS);
  localparam mat_t MAT_B = pole_matrix(1'b1, NS);

  localparam logic signed [58:0] TRnd = 59'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [FW-1:0] OMax = {{(FW-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
  localparam logic signed [FW-1:0] OMin = {{(FW-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}};

  // ---------------- configuration ----------------
  logic                     epoch_q;
  logic signed [23:0]       su_q;
  logic signed [23:0]       sv_q;
  logic signed [23:0]       sw_q;
  logic        [24:0]       disk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= 1'b0;
      su_q    <= SUN_U_RST;
      sv_q    <= SUN_V_RST;
      sw_q    <= SUN_W_RST;
      disk_q  <= DISK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_EPOCH: epoch_q <= cfg_data_i[0];
        CFG_SUN_U:       su_q    <= cfg_data_i[23:0];
        CFG_SUN_V:       sv_q    <= cfg_data_i[23:0];
        CFG_SUN_W:       sw_q    <= cfg_data_i[23:0];
        CFG_DISK_ROT:    disk_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en           = !vld_q[LAT-1] || vel_o.ready;
  assign star_i.ready = en;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], star_i.valid};
    end
  end

  // ---------------- angle reduction ----------------
  function automatic ang_t fold(logic [39:0] r);
    logic signed [40:0] s;
    ang_t               a;
    s     = signed'({1'b0, r});
    a.neg = 1'b0;
    if (s >= HF) s = s - 41'(KF);
    if (s > QF) begin
      s     = s - 41'(HF);
      a.neg = 1'b1;
    end else if (s < -QF) begin
      s     = s + 41'(HF);
      a.neg = 1'b1;
    end
    a.z = 33'(s <<< (24 - FRAC_BITS));
    return a;
  endfunction

  logic [39:0] ra_r;
  logic [39:0] dec_r;

  // Reduce both angles to one turn
  always_comb begin
    ra_r  = 40'(star_i.ra_angle);
    dec_r = 40'(40'(star_i.dec_angle) + 40'(DOFF));
    for (int j = RQB - 1; j >= 0; j--) begin
      if (ra_r >= 40'(KF <<< j)) ra_r = ra_r - 40'(KF <<< j);
    end
    for (int j = DQB - 1; j >= 0; j--) begin
      if (dec_r >= 40'(KF <<< j)) dec_r = dec_r - 40'(KF <<< j);
    end
  end

  ang_t               ra_ang_q;
  ang_t               dec_ang_q;
  logic        [22:0] dist_q;
  logic signed [31:0] pma0_q;
  logic signed [31:0] pmd0_q;
  logic signed [28:0] vr0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_ang_q  <= fold(ra_r);
      dec_ang_q <= fold(dec_r);
      dist_q    <= star_i.distance;
      pma0_q    <= star_i.pm_ra;
      pmd0_q    <= star_i.pm_dec;
      vr0_q     <= star_i.radial_speed;
    end
  end

  // ---------------- tangential speeds ----------------
  logic        [45:0]   dk_p;
  logic        [25:0]   dk_q;
  logic signed [31:0]   pma1_q;
  logic signed [31:0]   pmd1_q;
  logic signed [28:0]   vr1_q;
  logic signed [58:0]   ta_p;
  logic signed [58:0]   td_p;
  logic signed [TW-1:0] ta_q;
  logic signed [TW-1:0] td_q;
  logic signed [28:0]   vr2_q;

  assign dk_p = 46'(dist_q) * 46'(KTAN_Q20);
  assign ta_p = 59'(pma1_q) * signed'(59'(dk_q)) + TRnd;
  assign td_p = 59'(pmd1_q) * signed'(59'(dk_q)) + TRnd;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dk_q   <= 26'((dk_p + 46'(1 << 19)) >> 20);
      pma1_q <= pma0_q;
      pmd1_q <= pmd0_q;
      vr1_q  <= vr0_q;
      ta_q   <= TW'(ta_p >>> FRAC_BITS);
      td_q   <= TW'(td_p >>> FRAC_BITS);
      vr2_q  <= vr1_q;
    end
  end

  // Delay side data to meet the CORDIC outputs
  logic signed [28:0]   vrd_q [NS-1];
  logic signed [TW-1:0] tad_q [NS-1];
  logic signed [TW-1:0] tdd_q [NS-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      vrd_q[0] <= vr2_q;
      tad_q[0] <= ta_q;
      tdd_q[0] <= td_q;
      for (int k = 1; k < NS - 1; k++) begin
        vrd_q[k] <= vrd_q[k-1];
        tad_q[k] <= tad_q[k-1];
        tdd_q[k] <= tdd_q[k-1];
      end
    end
  end

  // ---------------- sine and cosine ----------------
  logic signed [31:0] ca;
  logic signed [31:0] sa;
  logic signed [31:0] cd;
  logic signed [31:0] sd;

  pmgv_cordic #(.STAGES(NS)) u_cordic_ra (
    .clk_i (clk_i), .en_i (en), .ang_i (ra_ang_q), .cos_o (ca), .sin_o (sa)
  );
  pmgv_cordic #(.STAGES(NS)) u_cordic_dec (
    .clk_i (clk_i), .en_i (en), .ang_i (dec_ang_q), .cos_o (cd), .sin_o (sd)
  );

  // ---------------- angle products ----------------
  logic signed [32:0] cacd;
  logic signed [32:0] sacd;
  logic signed [32:0] casd;
  logic signed [32:0] sasd;

  pmgv_mulq #(.AW(32), .BW(32)) u_m_cacd (.clk_i(clk_i), .en_i(en), .a_i(ca), .b_i(cd), .p_o(cacd));
  pmgv_mulq #(.AW(32), .BW(32)) u_m_sacd (.clk_i(clk_i), .en_i(en), .a_i(sa), .b_i(cd), .p_o(sacd));
  pmgv_mulq #(.AW(32), .BW(32)) u_m_casd (.clk_i(clk_i), .en_i(en), .a_i(ca), .b_i(sd), .p_o(casd));
  pmgv_mulq #(.AW(32), .BW(32)) u_m_sasd (.clk_i(clk_i), .en_i(en), .a_i(sa), .b_i(sd), .p_o(sasd));

  logic signed [31:0]   ca_p [2];
  logic signed [31:0]   sa_p [2];
  logic signed [31:0]   cd_p [2];
  logic signed [31:0]   sd_p [2];
  logic signed [28:0]   vr_p [2];
  logic signed [TW-1:0] ta_pp [2];
  logic signed [TW-1:0] td_pp [2];

  // Hold operands across the first multiply layer
  always_ff @(posedge clk_i) begin
    if (en) begin
      ca_p[0]  <= ca;
      sa_p[0]  <= sa;
      cd_p[0]  <= cd;
      sd_p[0]  <= sd;
      vr_p[0]  <= vrd_q[NS-2];
      ta_pp[0] <= tad_q[NS-2];
      td_pp[0] <= tdd_q[NS-2];
      ca_p[1]  <= ca_p[0];
      sa_p[1]  <= sa_p[0];
      cd_p[1]  <= cd_p[0];
      sd_p[1]  <= sd_p[0];
      vr_p[1]  <= vr_p[0];
      ta_pp[1] <= ta_pp[0];
      td_pp[1] <= td_pp[0];
    end
  end

  // ---------------- equatorial velocity ----------------
  logic signed [29:0] m_vcc;
  logic signed [29:0] m_vsc;
  logic signed [29:0] m_vsd;
  logic signed [TW:0] m_tsa;
  logic signed [TW:0] m_tcs;
  logic signed [TW:0] m_tca;
  logic signed [TW:0] m_tss;
  logic signed [TW:0] m_tcd;

  pmgv_mulq #(.AW(29), .BW(33)) u_m_vcc (.clk_i(clk_i), .en_i(en), .a_i(vr_p[1]), .b_i(cacd), .p_o(m_vcc));
  pmgv_mulq #(.AW(29), .BW(33)) u_m_vsc (.clk_i(clk_i), .en_i(en), .a_i(vr_p[1]), .b_i(sacd), .p_o(m_vsc));
  pmgv_mulq #(.AW(29), .BW(32)) u_m_vsd (.clk_i(clk_i), .en_i(en), .a_i(vr_p[1]), .b_i(sd_p[1]), .p_o(m_vsd));
  pmgv_mulq #(.AW(TW), .BW(32)) u_m_tsa (.clk_i(clk_i), .en_i(en), .a_i(ta_pp[1]), .b_i(sa_p[1]), .p_o(m_tsa));
  pmgv_mulq #(.AW(TW), .BW(33)) u_m_tcs (.clk_i(clk_i), .en_i(en), .a_i(td_pp[1]), .b_i(casd), .p_o(m_tcs));
  pmgv_mulq #(.AW(TW), .BW(32)) u_m_tca (.clk_i(clk_i), .en_i(en), .a_i(ta_pp[1]), .b_i(ca_p[1]), .p_o(m_tca));
  pmgv_mulq #(.AW(TW), .BW(33)) u_m_tss (.clk_i(clk_i), .en_i(en), .a_i(td_pp[1]), .b_i(sasd), .p_o(m_tss));
  pmgv_mulq #(.AW(TW), .BW(32)) u_m_tcd (.clk_i(clk_i), .en_i(en), .a_i(td_pp[1]), .b_i(cd_p[1]), .p_o(m_tcd));

  logic signed [EW-1:0] ex_q;
  logic signed [EW-1:0] ey_q;
  logic signed [EW-1:0] ez_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q <= EW'(m_vcc) - EW'(m_tsa) - EW'(m_tcs);
      ey_q <= EW'(m_vsc) + EW'(m_tca) - EW'(m_tss);
      ez_q <= EW'(m_vsd) + EW'(m_tcd);
    end
  end

  // ---------------- pole rotation ----------------
  mat_t               mat;
  logic signed [EW:0] mp [9];

  assign mat = epoch_q ? MAT_B : MAT_J;

  for (genvar r = 0; r < 3; r++) begin : g_row
    pmgv_mulq #(.AW(EW), .BW(32)) u_m_x (
      .clk_i(clk_i), .en_i(en), .a_i(ex_q), .b_i(signed'(mat[3*r])), .p_o(mp[3*r])
    );
    pmgv_mulq #(.AW(EW), .BW(32)) u_m_y (
      .clk_i(clk_i), .en_i(en), .a_i(ey_q), .b_i(signed'(mat[3*r+1])), .p_o(mp[3*r+1])
    );
    pmgv_mulq #(.AW(EW), .BW(32)) u_m_z (
      .clk_i(clk_i), .en_i(en), .a_i(ez_q), .b_i(signed'(mat[3*r+2])), .p_o(mp[3*r+2])
    );
  end

  logic signed [UW-1:0] u_q;
  logic signed [UW-1:0] v_q;
  logic signed [UW-1:0] w_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= UW'(mp[0]) + UW'(mp[1]) + UW'(mp[2]);
      v_q <= UW'(mp[3]) + UW'(mp[4]) + UW'(mp[5]);
      w_q <= UW'(mp[6]) + UW'(mp[7]) + UW'(mp[8]);
    end
  end

  // ---------------- solar motion and saturation ----------------
  logic signed [FW-1:0] xs;
  logic signed [FW-1:0] ys;
  logic signed [FW-1:0] zs;
  logic signed [VEL_W-1:0] x_d;
  logic signed [VEL_W-1:0] y_d;
  logic signed [VEL_W-1:0] z_d;
  logic                    sat_d;

  assign xs = FW'(su_q) - FW'(u_q);
  assign ys = -(FW'(v_q) + FW'(sv_q) + FW'(signed'({1'b0, disk_q})));
  assign zs = FW'(w_q) + FW'(sw_q);

  // Clip each component to the output range
  always_comb begin
    sat_d = 1'b0;
    if (xs > OMax) begin
      x_d = OMax[VEL_W-1:0]; sat_d = 1'b1;
    end else if (xs < OMin) begin
      x_d = OMin[VEL_W-1:0]; sat_d = 1'b1;
    end else begin
      x_d = xs[VEL_W-1:0];
    end
    if (ys > OMax) begin
      y_d = OMax[VEL_W-1:0]; sat_d = 1'b1;
    end else if (ys < OMin) begin
      y_d = OMin[VEL_W-1:0]; sat_d = 1'b1;
    end else begin
      y_d = ys[VEL_W-1:0];
    end
    if (zs > OMax) begin
      z_d = OMax[VEL_W-1:0]; sat_d = 1'b1;
    end else if (zs < OMin) begin
      z_d = OMin[VEL_W-1:0]; sat_d = 1'b1;
    end else begin
      z_d = zs[VEL_W-1:0];
    end
  end

  logic signed [VEL_W-1:0] vel_x_q;
  logic signed [VEL_W-1:0] vel_y_q;
  logic signed [VEL_W-1:0] vel_z_q;
  logic                    sat_q;

  // Output register; holds while the beat is stalled
  always_ff @(posedge clk_i) begin
    if (en) begin
      vel_x_q <= x_d;
      vel_y_q <= y_d;
      vel_z_q <= z_d;
      sat_q   <= sat_d;
    end
  end

  assign vel_o.valid     = vld_q[LAT-1];
  assign vel_o.vel_x     = vel_x_q;
  assign vel_o.vel_y     = vel_y_q;
  assign vel_o.vel_z     = vel_z_q;
  assign vel_o.saturated = sat_q;

  // ---------------- checks ----------------
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS+1] |-> (ca <= ONE_Q30 && ca >= -ONE_Q30 && sd <= ONE_Q30 && sd >= -ONE_Q30))
    else $error("CORDIC output outside unit range");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vel_o.valid && vel_o.saturated) |->
      (vel_x_q == OMax[VEL_W-1:0] || vel_x_q == OMin[VEL_W-1:0] ||
       vel_y_q == OMax[VEL_W-1:0] || vel_y_q == OMin[VEL_W-1:0] ||
       vel_z_q == OMax[VEL_W-1:0] || vel_z_q == OMin[VEL_W-1:0]))
    else $error("saturated flag without a clipped component");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-1] && !vel_o.ready) |=> $stable(vld_q))
    else $error("pipeline moved during an output stall");

endmodule

/* sim/proper_motion_to_galactic_velocity_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the galactic velocity unit: random stars against an
// in-bench bit-exact predictor, under random stalls and register settings.
// Depends on pmgv_pkg, pmgv_in_if, pmgv_out_if and the unit itself.
module proper_motion_to_galactic_velocity_unit_tb;
  import pmgv_pkg::*;

  localparam int                 STAGES      = 18;
  localparam int                 LATENCY     = STAGES + 11;
  localparam int                 CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
  localparam longint             OUT_HI      = (64'sd1 <<< 47) - 1;
  localparam longint             OUT_LO      = -(64'sd1 <<< 47);
  localparam longint             Q30_ONE     = 64'sd1 <<< 30;
  localparam longint             DEG         = 64'sd1 <<< 24;

  typedef struct {
    logic        [24:0] ra;
    logic signed [23:0] dec;
    logic        [22:0] dist_kpc;
    logic signed [31:0] pm_ra;
    logic signed [31:0] pm_dec;
    logic signed [28:0] vr;
  } star_t;

  typedef struct {
    logic [47:0] vx;
    logic [47:0] vy;
    logic [47:0] vz;
    logic        sat;
  } velocity_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pmgv_in_if  star_if ();
  pmgv_out_if vel_if ();

  proper_motion_to_galactic_velocity_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .star_i     (star_if),
    .vel_o      (vel_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow configuration
  bit     epoch_sel;
  longint sun_u;
  longint sun_v;
  longint sun_w;
  longint disk_rot;
  longint pole_m [2][9];

  star_t     star_q [$];
  velocity_t velocity_q [$];
  int        idle_in_pct;
  int        idle_out_pct;
  int        mismatches;
  int        cycles;
  bit        star_took;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_q30(longint v);
    if (v > Q30_ONE) return Q30_ONE;
    if (v < -Q30_ONE) return -Q30_ONE;
    return v;
  endfunction

  // round(a * b / 2^30), half up, on a wide product
  function automatic longint mul_q30(longint a, longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] p;
    wa = 128'(a);
    wb = 128'(b);
    p  = wa * wb + (128'sd1 <<< 29);
    return longint'(p >>> 30);
  endfunction

  // Rotation-mode CORDIC on an angle in 2^-24 degree
  function automatic void cordic_sincos(longint ang, output longint c, output longint s);
    longint x;
    longint y;
    longint t;
    longint z;
    bit     flip;
    x    = 64'sd652032874;
    y    = 0;
    flip = 1'b0;
    z    = ang % (360 * DEG);
    if (z < 0) z += 360 * DEG;
    if (z >= 180 * DEG) z -= 360 * DEG;
    if (z > 90 * DEG) begin
      z -= 180 * DEG;
      flip = 1'b1;
    end else if (z < -90 * DEG) begin
      z += 180 * DEG;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      t = x;
      if (z >= 0) begin
        x -= y >>> i;
        y += t >>> i;
        z -= longint'(ATAN_LUT[i]);
      end else begin
        x += y >>> i;
        y -= t >>> i;
        z += longint'(ATAN_LUT[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_q30(x);
    s = clamp_q30(y);
  endfunction

  function automatic void build_pole(int ep, longint a, longint d, longint th);
    longint ca, sa, cd, sd, ct, st;
    cordic_sincos(a, ca, sa);
    cordic_sincos(d, cd, sd);
    cordic_sincos(th, ct, st);
    pole_m[ep][0] = clamp_q30(-mul_q30(mul_q30(ca, ct), sd) - mul_q30(sa, st));
    pole_m[ep][1] = clamp_q30(-mul_q30(mul_q30(ct, sa), sd) + mul_q30(ca, st));
    pole_m[ep][2] = clamp_q30(mul_q30(cd, ct));
    pole_m[ep][3] = clamp_q30(mul_q30(ct, sa) - mul_q30(mul_q30(ca, sd), st));
    pole_m[ep][4] = clamp_q30(-mul_q30(mul_q30(sa, sd), st) - mul_q30(ca, ct));
    pole_m[ep][5] = clamp_q30(mul_q30(cd, st));
    pole_m[ep][6] = clamp_q30(mul_q30(cd, ca));
    pole_m[ep][7] = clamp_q30(mul_q30(cd, sa));
    pole_m[ep][8] = sd;
  endfunction

  function automatic longint tangential_speed(longint pm, longint dist_kpc);
    longint dk;
    dk = (dist_kpc * longint'(KTAN_Q20) + (64'sd1 <<< 19)) >>> 20;
    return (pm * dk + (64'sd1 <<< 15)) >>> 16;
  endfunction

  function automatic longint clip48(longint v, inout bit flag);
    if (v > OUT_HI) begin
      flag = 1'b1;
      return OUT_HI;
    end
    if (v < OUT_LO) begin
      flag = 1'b1;
      return OUT_LO;
    end
    return v;
  endfunction

  function automatic velocity_t galactic_velocity(star_t s);
    longint    ca, sa, cd, sd, ta, td, ex, ey, ez, u, v, w, vr;
    bit        flag;
    velocity_t r;
    flag = 1'b0;
    vr   = longint'(s.vr);
    cordic_sincos(longint'(s.ra) * 256, ca, sa);
    cordic_sincos(longint'(s.dec) * 256, cd, sd);
    ta = tangential_speed(longint'(s.pm_ra), longint'(s.dist_kpc));
    td = tangential_speed(longint'(s.pm_dec), longint'(s.dist_kpc));
    ex = mul_q30(vr, mul_q30(ca, cd)) - mul_q30(ta, sa) - mul_q30(td, mul_q30(ca, sd));
    ey = mul_q30(vr, mul_q30(sa, cd)) + mul_q30(ta, ca) - mul_q30(td, mul_q30(sa, sd));
    ez = mul_q30(vr, sd) + mul_q30(td, cd);
    u = mul_q30(ex, pole_m[epoch_sel][0]) + mul_q30(ey, pole_m[epoch_sel][1])
      + mul_q30(ez, pole_m[epoch_sel][2]);
    v = mul_q30(ex, pole_m[epoch_sel][3]) + mul_q30(ey, pole_m[epoch_sel][4])
      + mul_q30(ez, pole_m[epoch_sel][5]);
    w = mul_q30(ex, pole_m[epoch_sel][6]) + mul_q30(ey, pole_m[epoch_sel][7])
      + mul_q30(ez, pole_m[epoch_sel][8]);
    r.vx  = 48'(clip48(-u + sun_u, flag));
    r.vy  = 48'(clip48(-(v + sun_v + disk_rot), flag));
    r.vz  = 48'(clip48(w + sun_w, flag));
    r.sat = flag;
    return r;
  endfunction

  function automatic star_t make_star(longint ra, longint dec, longint dist_kpc,
                                      longint pa, longint pd, longint vr);
    star_t s;
    s.ra       = 25'(ra);
    s.dec      = 24'(dec);
    s.dist_kpc = 23'(dist_kpc);
    s.pm_ra    = 32'(pa);
    s.pm_dec   = 32'(pd);
    s.vr       = 29'(vr);
    return s;
  endfunction

  // Mostly in-range stars, a quarter with every bit random
  function automatic star_t random_star();
    if ($urandom_range(0, 3) == 0)
      return make_star($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    return make_star($urandom_range(0, 23592960),
                     longint'($urandom_range(0, 11796480)) - 5898240,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6553600)
                                                 : $urandom_range(1, 655360),
                     longint'($urandom_range(0, 32'h8000_0000)) - 1073741824,
                     longint'($urandom_range(0, 32'h8000_0000)) - 1073741824,
                     longint'($urandom_range(0, 268435456)) - 134217728);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAME_EPOCH: epoch_sel = val[0];
      CFG_SUN_U:       sun_u = val;
      CFG_SUN_V:       sun_v = val;
      CFG_SUN_W:       sun_w = val;
      CFG_DISK_ROT:    disk_rot = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(bit ep, longint u, longint v, longint w, longint d);
    write_reg(CFG_FRAME_EPOCH, longint'(ep));
    write_reg(CFG_SUN_U, u);
    write_reg(CFG_SUN_V, v);
    write_reg(CFG_SUN_W, w);
    write_reg(CFG_DISK_ROT, d);
  endtask

  // Hold until every queued star is in and every velocity is back
  task automatic drain();
    while (star_q.size() != 0 || star_if.valid || velocity_q.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Drive star beats; advance only on an accepted beat
  always @(negedge clk_i) begin
    if (rst_ni && (!star_if.valid || star_took)) begin
      if (star_q.size() != 0 && $urandom_range(1, 100) > idle_in_pct) begin
        star_t s;
        s = star_q.pop_front();
        star_if.ra_angle     <= s.ra;
        star_if.dec_angle    <= s.dec;
        star_if.distance     <= s.dist_kpc;
        star_if.pm_ra        <= s.pm_ra;
        star_if.pm_dec       <= s.pm_dec;
        star_if.radial_speed <= s.vr;
        star_if.valid        <= 1'b1;
      end else begin
        star_if.valid <= 1'b0;
      end
    end
  end

  // Random backpressure on results
  always @(negedge clk_i) begin
    if (rst_ni) vel_if.ready <= ($urandom_range(1, 100) > idle_out_pct);
  end

  // Predict on accepted stars, check accepted velocities
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    star_took <= star_if.valid && star_if.ready;
    if (star_if.valid && star_if.ready) begin
      star_t s;
      s.ra       = star_if.ra_angle;
      s.dec      = star_if.dec_angle;
      s.dist_kpc = star_if.distance;
      s.pm_ra    = star_if.pm_ra;
      s.pm_dec   = star_if.pm_dec;
      s.vr       = star_if.radial_speed;
      velocity_q.push_back(galactic_velocity(s));
    end
    if (vel_if.valid && vel_if.ready) begin
      if (velocity_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected velocity beat at cycle %0d", cycles);
      end else begin
        velocity_t e;
        e = velocity_q.pop_front();
        if (vel_if.vel_x !== e.vx || vel_if.vel_y !== e.vy || vel_if.vel_z !== e.vz
            || vel_if.saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %b got %h %h %h %b", e.vx, e.vy, e.vz,
                     e.sat, vel_if.vel_x, vel_if.vel_y, vel_if.vel_z, vel_if.saturated);
        end
      end
    end
  end

  initial begin
    longint ends [4];
    cycles       = 0;
    mismatches   = 0;
    star_took    = 1'b0;
    idle_in_pct  = 35;
    idle_out_pct = 48;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    star_if.valid        = 1'b0;
    star_if.ra_angle     = '0;
    star_if.dec_angle    = '0;
    star_if.distance     = '0;
    star_if.pm_ra        = '0;
    star_if.pm_dec       = '0;
    star_if.radial_speed = '0;
    vel_if.ready         = 1'b0;
    epoch_sel = 1'b0;
    sun_u     = -589824;
    sun_v     = 786432;
    sun_w     = 458752;
    disk_rot  = 14417920;
    build_pole(0, 64'sd3235645174, 64'sd455136530, 64'sd2062455352);
    build_pole(1, 64'sd3225419776, 64'sd459695718, 64'sd2063597568);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed stars with reset settings: field extremes, quadrant edges,
    // wrapped angles, out-of-range declination, zero distance
    star_q.push_back(make_star(0, 0, 65536, 0, 0, 0));
    star_q.push_back(make_star(23592960, 5898240, 6553600, 1073741824, -1073741824,
                               134217728));
    star_q.push_back(make_star(33554431, -8388608, 8388607, 32'h7fff_ffff,
                               32'h8000_0000, -134217728));
    star_q.push_back(make_star(33554431, 8388607, 8388607, 32'h8000_0000,
                               32'h8000_0000, 29'h0fff_ffff));
    star_q.push_back(make_star(0, -5898240, 8388607, 32'h7fff_ffff, 32'h7fff_ffff,
                               29'h1000_0000));
    star_q.push_back(make_star(90 * 65536, 0, 65536, 65536, 65536, 65536));
    star_q.push_back(make_star(180 * 65536, 90 * 65536, 65536, 65536, 0, 65536));
    star_q.push_back(make_star(270 * 65536, -90 * 65536, 65536, 0, 65536, 65536));
    star_q.push_back(make_star(400 * 65536, 100 * 65536, 1, 65536, 65536, -65536));
    star_q.push_back(make_star(123456, -95 * 65536, 0, 1073741824, 1073741824, 65536));
    star_q.push_back(make_star(777777, 1234567, 0, -1073741824, 5, -5));
    star_q.push_back(make_star(1, -1, 1, -1, 1, -1));
    star_q.push_back(make_star(359 * 65536, 45 * 65536, 327680, 1000000, -2000000,
                               3000000));
    repeat (160) star_q.push_back(random_star());
    drain();

    // Unused index must leave everything alone
    write_reg(CFG_UNUSED, 25'h1ff_ffff);
    for (int ph = 1; ph <= 5; ph++) begin
      idle_in_pct  = (ph <= 1) ? 35 : (ph <= 3) ? 48 : 0;
      idle_out_pct = (ph <= 1) ? 48 : (ph <= 3) ? 35 : 0;
      case (ph)
        1: set_regs(1'b1, -6553600, 6553600, -6553600, 26214400);
        2: set_regs(1'b0, 6553600, -6553600, 6553600, 0);
        default: begin
          for (int k = 0; k < 3; k++)
            ends[k] = longint'($urandom_range(0, 13107200)) - 6553600;
          ends[3] = longint'($urandom_range(0, 26214400));
          set_regs(1'($urandom_range(0, 1)), ends[0], ends[1], ends[2], ends[3]);
        end
      endcase
      repeat (160) star_q.push_back(random_star());
      drain();
    end

    if (mismatches == 0 && velocity_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pmgv_pkg.sv
sv/pmgv_in_if.sv
sv/pmgv_out_if.sv
sv/pmgv_mulq.sv
sv/pmgv_cordic.sv
sv/proper_motion_to_galactic_velocity_unit.sv
sim/proper_motion_to_galactic_velocity_unit_tb.sv
